### rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/tt_bank_pkg.sv
package tt_bank_pkg;

	// Field widths of the item and result.
	localparam int OP_W       = 2;
	localparam int ID_W       = 2;
	localparam int IVL_FLD_W  = 20;
	localparam int MASK_W     = 4;
	localparam int DUE_W      = 32;
	localparam int SEED_W     = 16;

	// Generator word and the bit counter of the serial remainder unit.
	localparam int DRAW_W     = 32;
	localparam int DCNT_W     = 5;

	// Soonest-fire value reported when no timer runs.
	localparam logic signed [DUE_W-1:0] NONE_DUE = 32'sh7FFF_FFFF;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [ID_W-1:0]      timer_id;
		logic [IVL_FLD_W-1:0] min_interval;
		logic [IVL_FLD_W-1:0] max_interval;
	} tt_in_t;

	typedef struct packed {
		logic [MASK_W-1:0]        fired_mask;
		logic [MASK_W-1:0]        running_mask;
		logic                     any_running;
		logic signed [DUE_W-1:0]  next_due;
	} tt_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_START_FIN,
		S_PICK,
		S_PICK_FIN,
		S_SCAN,
		S_SUMMARY
	} tt_state_t;

endpackage

### rtl/trickle_timer_bank_unit.sv
// A stop or an unknown op goes straight to the status walk over all TIMERS timers; a tick
// first scans the timers, and a start with a valid id first draws its offset and fire time.
// Each timer firing on a tick runs a draw through the one-bit-per-cycle remainder unit
// (32 steps per draw) that all draws share. Throughput: one item at a time; busy stays high
// until the done cycle. Reset: arst_n clears all timers, time to zero, the generator to one
// and the seed to zero. done is high for a single cycle with the result; no stall.
`include "assert_macros.svh"

module trickle_timer_bank_unit
	import tt_bank_pkg::*;
#(
	parameter int TIMERS        = 4,
	parameter int INTERVAL_BITS = 20,
	parameter int TIME_BITS     = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tt_in_t            item,
	output logic              busy,
	output logic              done,
	output tt_out_t           result,
	input  logic              cfg_we,
	input  logic [SEED_W-1:0] cfg_wdata
);

	localparam int IW  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int IB  = INTERVAL_BITS;
	localparam int TB  = TIME_BITS;
	localparam int SW  = (TB > IB) ? TB : IB;
	localparam int CW  = (IB > IVL_FLD_W) ? IB : IVL_FLD_W;
	localparam int MW  = (TIMERS > MASK_W) ? TIMERS : MASK_W;
	localparam logic [CW-1:0] IVL_MAX = CW'((64'd1 << IB) - 64'd1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMERS - 1);

	// One xorshift step of the generator.
	function automatic logic [DRAW_W-1:0] xorshift(input logic [DRAW_W-1:0] v);
		logic [DRAW_W-1:0] x;
		begin
			x = v;
			x = x ^ (x << 13);
			x = x ^ (x >> 17);
			x = x ^ (x << 5);
			return x;
		end
	endfunction

	// Zero becomes one, anything above the interval range saturates.
	function automatic logic [IB-1:0] clean_ivl(input logic [IVL_FLD_W-1:0] v);
		logic [CW-1:0] e;
		begin
			e = CW'(v);
			if (e > IVL_MAX) begin
				e = IVL_MAX;
			end
			if (e == '0) begin
				e = CW'(1);
			end
			return IB'(e);
		end
	endfunction

	// Control state.
	tt_state_t         state_q, state_d, mod_ret_q;
	logic [IW-1:0]     idx_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [TIMERS-1:0] running_q;
	logic [TB-1:0]     time_q;
	logic [DRAW_W-1:0] prng_q;
	logic [SEED_W-1:0] seed_q;
	logic              done_q;

	// Item and per-timer storage.
	logic [OP_W-1:0]   op_q;
	logic [IB-1:0]     lo_q, hi_q;
	logic [TIMERS-1:0] fired_q;
	logic [TB-1:0]     ivl_start_q [TIMERS];
	logic [TB-1:0]     fire_q      [TIMERS];
	logic [IB-1:0]     ivl_now_q   [TIMERS];
	logic [IB-1:0]     ivl_floor_q [TIMERS];
	logic [IB-1:0]     ivl_ceil_q  [TIMERS];
	logic signed [DUE_W-1:0] best_q;
	tt_out_t           result_q;

	// Serial remainder unit.
	logic [DRAW_W-1:0] dvd_q;
	logic [IB-1:0]     div_q, rem_q;
	logic [IB:0]       rem_sh;

	// Decoded signals.
	logic              accept, id_ok, last_idx, due;
	logic [TB-1:0]     diff;
	logic signed [DUE_W-1:0] rem_due, best_n;
	logic [IB-1:0]     cur_ivl, cur_half, cur_span, new_ivl;
	logic [IB:0]       dbl_ivl;
	logic [DRAW_W-1:0] next_draw, seed_draw;
	logic [MW-1:0]     fired_ext, run_ext;

	assign accept   = start && !busy;
	assign id_ok    = 32'(item.timer_id) < 32'(TIMERS);
	assign last_idx = (idx_q == LAST_IDX);

	// Remaining time of the addressed timer, as a signed value.
	assign diff    = fire_q[idx_q] - time_q;
	assign rem_due = DUE_W'($signed(diff));
	assign due     = running_q[idx_q] && (diff[TB-1] || (diff == '0));
	assign best_n  = (running_q[idx_q] && (rem_due < best_q)) ? rem_due : best_q;

	// Interval arithmetic of the addressed timer.
	assign cur_ivl  = ivl_now_q[idx_q];
	assign cur_half = cur_ivl >> 1;
	assign cur_span = cur_ivl - cur_half;
	assign dbl_ivl  = {cur_ivl, 1'b0};
	assign new_ivl  = (dbl_ivl > {1'b0, ivl_ceil_q[idx_q]}) ? ivl_ceil_q[idx_q] : IB'(dbl_ivl);

	// Generator draws.
	assign next_draw = xorshift(prng_q);
	assign seed_draw = xorshift(DRAW_W'(seed_q) | DRAW_W'(1));

	// One restoring step of the remainder: shift in a dividend bit, subtract if it fits.
	assign rem_sh = {rem_q, dvd_q[DRAW_W-1]};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.op)
						OP_START: state_d = id_ok ? S_MOD : S_SUMMARY;
						OP_TICK:  state_d = S_SCAN;
						default:  state_d = S_SUMMARY;
					endcase
				end
			end
			S_MOD: begin
				if (cnt_q == '1) begin
					state_d = mod_ret_q;
				end
			end
			S_START_FIN: state_d = S_PICK;
			S_PICK:      state_d = S_MOD;
			S_PICK_FIN: begin
				state_d = (op_q == OP_TICK && !last_idx) ? S_SCAN : S_SUMMARY;
			end
			S_SCAN: begin
				if (due) begin
					state_d = S_PICK;
				end else if (last_idx) begin
					state_d = S_SUMMARY;
				end
			end
			S_SUMMARY: begin
				if (last_idx) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		busy = (state_q != S_IDLE);
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mod_ret_q <= S_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			running_q <= '0;
			time_q    <= '0;
			prng_q    <= DRAW_W'(1);
			seed_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_SUMMARY) && last_idx;
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						cnt_q <= '0;
						case (item.op)
							OP_START: begin
								if (id_ok) begin
									idx_q     <= IW'(item.timer_id);
									prng_q    <= seed_draw;
									mod_ret_q <= S_START_FIN;
								end
							end
							OP_STOP: begin
								if (id_ok) begin
									running_q[IW'(item.timer_id)] <= 1'b0;
								end
							end
							OP_TICK: time_q <= time_q + TB'(1);
							default: ;
						endcase
					end
				end
				S_MOD: cnt_q <= cnt_q + DCNT_W'(1);
				S_START_FIN: running_q[idx_q] <= 1'b1;
				S_PICK: begin
					prng_q    <= next_draw;
					cnt_q     <= '0;
					mod_ret_q <= S_PICK_FIN;
				end
				S_PICK_FIN: begin
					idx_q <= (op_q == OP_TICK && !last_idx) ? idx_q + IW'(1) : '0;
				end
				S_SCAN: begin
					if (!due) begin
						idx_q <= last_idx ? '0 : idx_q + IW'(1);
					end
				end
				S_SUMMARY: idx_q <= last_idx ? '0 : idx_q + IW'(1);
				default: ;
			endcase
		end
	end

	// Datapath: item fields, timer storage, remainder unit and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= item.op;
					lo_q    <= clean_ivl(item.min_interval);
					hi_q    <= clean_ivl(item.max_interval);
					fired_q <= '0;
					best_q  <= NONE_DUE;
					dvd_q   <= seed_draw;
					div_q   <= clean_ivl(item.min_interval);
					rem_q   <= '0;
				end
			end
			S_MOD: begin
				if (rem_sh >= {1'b0, div_q}) begin
					rem_q <= IB'(rem_sh - {1'b0, div_q});
				end else begin
					rem_q <= IB'(rem_sh);
				end
				dvd_q <= dvd_q << 1;
			end
			S_START_FIN: begin
				ivl_start_q[idx_q] <= TB'(SW'(time_q) + SW'(rem_q));
				ivl_now_q[idx_q]   <= lo_q;
				ivl_floor_q[idx_q] <= lo_q;
				ivl_ceil_q[idx_q]  <= hi_q;
			end
			S_PICK: begin
				dvd_q <= next_draw;
				div_q <= cur_span;
				rem_q <= '0;
			end
			S_PICK_FIN: begin
				fire_q[idx_q] <= TB'(SW'(ivl_start_q[idx_q]) + SW'(cur_half) + SW'(rem_q));
			end
			S_SCAN: begin
				if (due) begin
					ivl_start_q[idx_q] <= TB'(SW'(ivl_start_q[idx_q]) + SW'(cur_ivl));
					ivl_now_q[idx_q]   <= new_ivl;
					fired_q[idx_q]     <= 1'b1;
				end
			end
			S_SUMMARY: begin
				best_q <= best_n;
				if (last_idx) begin
					result_q.fired_mask   <= fired_ext[MASK_W-1:0];
					result_q.running_mask <= run_ext[MASK_W-1:0];
					result_q.any_running  <= |running_q;
					result_q.next_due     <= best_n;
				end
			end
			default: ;
		endcase
	end

	assign fired_ext = MW'(fired_q);
	assign run_ext   = MW'(running_q);

	assign done   = done_q;
	assign result = result_q;

	// The floor is kept with each timer; only the interval check below reads it.
	`ASSERT_IMPL(a_floor_le_now, (state_q == S_SCAN) && running_q[idx_q],
		ivl_floor_q[idx_q] <= ivl_now_q[idx_q] || ivl_ceil_q[idx_q] < ivl_floor_q[idx_q],
		"current interval fell below its floor")
	`ASSERT_IMPL(a_rem_bound, (state_q == S_MOD), (div_q != '0) && (rem_q < div_q),
		"remainder unit left its range")
	`ASSERT_IMPL(a_fire_tick_only, done && (result.fired_mask != '0), op_q == OP_TICK,
		"fire reported for an item that was not a tick")
	`ASSERT_NEXT(a_done_after_walk, (state_q == S_SUMMARY) && last_idx, done && !busy,
		"result not delivered after the status walk")

endmodule
